### hw/rtl/clps_pkg.sv
// shared types, constants and helper functions for the cell list pair search unit
// no dependencies

package clps_pkg;

    localparam int GRID_MAX   = 16;
    localparam int CELL_CAP   = 4;
    localparam int COORD_BITS = 24;
    localparam int ID_BITS    = 16;

    localparam int DIM        = GRID_MAX + 2;
    localparam int NCELLS     = DIM * DIM * DIM;
    localparam int NSLOTS     = NCELLS * CELL_CAP;
    localparam int CI_BITS    = $clog2(NCELLS);
    localparam int SA_BITS    = $clog2(NSLOTS);
    localparam int CW         = $clog2(DIM);
    localparam int FILL_BITS  = $clog2(CELL_CAP + 1);
    localparam int CUT_BITS   = 23;
    localparam int GRID_BITS  = 5;
    localparam int IN_CW      = 5;
    localparam int SL_BITS    = 2;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * CUT_BITS;
    localparam int ACC_BITS   = SQ_BITS + 2;
    localparam int DCNT_BITS  = $clog2(COORD_BITS);
    localparam int NSHELL     = 13;
    localparam int K_BITS     = 4;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_SCAN  = 2'd2;

    localparam logic [1:0] RES_OK   = 2'd0;
    localparam logic [1:0] RES_OOB  = 2'd1;
    localparam logic [1:0] RES_FULL = 2'd2;

    localparam logic [1:0] REG_CUTOFF = 2'd0;
    localparam logic [1:0] REG_GRID_X = 2'd1;
    localparam logic [1:0] REG_GRID_Y = 2'd2;
    localparam logic [1:0] REG_GRID_Z = 2'd3;

    localparam logic [1:0] SQ_CUT = 2'd3;

    typedef struct packed {
        logic [ID_BITS-1:0]           ident;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
    } slot_t;

    typedef struct packed {
        logic       latch;
        logic       clr_wr;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic [1:0] axis;
        logic       ld_rd;
        logic       ld_chk;
        logic       sc_rd;
        logic       me_rd;
        logic       me_latch;
        logic       cand_rd;
        logic       diff;
        logic       sq;
        logic       nbr_next;
        logic       lim_latch;
        logic       j_inc;
        logic       pend_load;
        logic       emit;
        logic       emit_pair;
    } clps_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic div_last;
        logic scan_ok;
        logic slot_ok;
        logic more;
        logic nbr_end;
        logic hit;
        logic have_pend;
        logic out_busy;
    } clps_stat_t;

    function automatic logic [CI_BITS-1:0] cell_index(input logic [CW-1:0] x,
                                                      input logic [CW-1:0] y,
                                                      input logic [CW-1:0] z);
        int v;
        v = int'(x) * DIM * DIM + int'(y) * DIM + int'(z);
        return CI_BITS'(v);
    endfunction

    // offset of half-shell neighbour k (1..13) from the scanned cell
    function automatic logic [CI_BITS-1:0] nbr_off(input logic [K_BITS-1:0] k);
        int dx;
        int dy;
        int dz;
        dx = 0;
        dy = 0;
        dz = 0;
        case (k)
            4'd1:  begin dx = 1;  dy = 0;  dz = 0;  end
            4'd2:  begin dx = 0;  dy = 1;  dz = 0;  end
            4'd3:  begin dx = 0;  dy = 0;  dz = 1;  end
            4'd4:  begin dx = 1;  dy = 1;  dz = 0;  end
            4'd5:  begin dx = 1;  dy = 0;  dz = 1;  end
            4'd6:  begin dx = 0;  dy = 1;  dz = 1;  end
            4'd7:  begin dx = 1;  dy = 1;  dz = 1;  end
            4'd8:  begin dx = 1;  dy = -1; dz = 0;  end
            4'd9:  begin dx = 1;  dy = 0;  dz = -1; end
            4'd10: begin dx = 1;  dy = -1; dz = -1; end
            4'd11: begin dx = -1; dy = -1; dz = 1;  end
            4'd12: begin dx = 0;  dy = -1; dz = 1;  end
            4'd13: begin dx = 1;  dy = -1; dz = 1;  end
            default: begin dx = 0; dy = 0; dz = 0; end
        endcase
        return CI_BITS'(dx * DIM * DIM + dy * DIM + dz);
    endfunction

    function automatic logic [SA_BITS-1:0] slot_addr(input logic [CI_BITS-1:0] ci,
                                                     input logic [FILL_BITS-1:0] s);
        return SA_BITS'(int'(ci) * CELL_CAP + int'(s));
    endfunction

endpackage

### hw/rtl/clps_ctrl.sv
// controller state machine of the cell list pair search unit
// depends on clps_pkg; drives the datapath by command and status structs

module clps_ctrl
    import clps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] kind,
    input  clps_stat_t st,
    output clps_cmd_t  cmd
);

    localparam logic [4:0] S_RST    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_CLR    = 5'd2;
    localparam logic [4:0] S_DIVI   = 5'd3;
    localparam logic [4:0] S_DIV    = 5'd4;
    localparam logic [4:0] S_DIVE   = 5'd5;
    localparam logic [4:0] S_LDRD   = 5'd6;
    localparam logic [4:0] S_LDCHK  = 5'd7;
    localparam logic [4:0] S_SCFILL = 5'd8;
    localparam logic [4:0] S_SCME   = 5'd9;
    localparam logic [4:0] S_SCMEW  = 5'd10;
    localparam logic [4:0] S_CCHK   = 5'd11;
    localparam logic [4:0] S_NBW    = 5'd12;
    localparam logic [4:0] S_CW     = 5'd13;
    localparam logic [4:0] S_SQ     = 5'd14;
    localparam logic [4:0] S_CMP    = 5'd15;
    localparam logic [4:0] S_END    = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] ax_reg;
    logic [1:0] ax_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST;
            ax_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        cmd        = '0;
        cmd.axis   = ax_reg;
        unique case (state_reg)
            S_RST:
            begin
                cmd.clr_wr = 1'b1;
                if (st.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch = 1'b1;
                    ax_next   = 2'd0;
                    case (kind)
                        KIND_CLEAR: state_next = S_CLR;
                        KIND_LOAD:  state_next = S_DIVI;
                        KIND_SCAN:  state_next = S_SCFILL;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.sweep_last)
                    state_next = S_FIN;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                    state_next = S_DIVE;
            end
            S_DIVE:
            begin
                cmd.div_store = 1'b1;
                if (ax_reg == 2'd2)
                begin
                    ax_next    = 2'd0;
                    state_next = S_LDRD;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_DIVI;
                end
            end
            S_LDRD:
            begin
                cmd.ld_rd  = 1'b1;
                state_next = S_LDCHK;
            end
            S_LDCHK:
            begin
                cmd.ld_chk = 1'b1;
                state_next = S_FIN;
            end
            S_SCFILL:
            begin
                if (st.scan_ok)
                begin
                    cmd.sc_rd  = 1'b1;
                    state_next = S_SCME;
                end
                else
                    state_next = S_FIN;
            end
            S_SCME:
            begin
                if (st.slot_ok)
                begin
                    cmd.me_rd  = 1'b1;
                    state_next = S_SCMEW;
                end
                else
                    state_next = S_FIN;
            end
            S_SCMEW:
            begin
                cmd.me_latch = 1'b1;
                cmd.sq       = 1'b1;
                cmd.axis     = SQ_CUT;
                state_next   = S_CCHK;
            end
            S_CCHK:
            begin
                if (st.more)
                begin
                    cmd.cand_rd = 1'b1;
                    state_next  = S_CW;
                end
                else if (st.nbr_end)
                    state_next = S_END;
                else
                begin
                    cmd.nbr_next = 1'b1;
                    state_next   = S_NBW;
                end
            end
            S_NBW:
            begin
                cmd.lim_latch = 1'b1;
                state_next    = S_CCHK;
            end
            S_CW:
            begin
                cmd.diff   = 1'b1;
                ax_next    = 2'd0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq = 1'b1;
                if (ax_reg == 2'd2)
                begin
                    ax_next    = 2'd0;
                    state_next = S_CMP;
                end
                else
                    ax_next = ax_reg + 2'd1;
            end
            S_CMP:
            begin
                if (!st.hit)
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_CCHK;
                end
                else if (!st.have_pend)
                begin
                    cmd.pend_load = 1'b1;
                    cmd.j_inc     = 1'b1;
                    state_next    = S_CCHK;
                end
                else if (!st.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_pair = 1'b1;
                    cmd.pend_load = 1'b1;
                    cmd.j_inc     = 1'b1;
                    state_next    = S_CCHK;
                end
            end
            S_END:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_pair = st.have_pend;
                    state_next    = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !st.out_busy)
        else $error("result written while output register held");

    a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && state_reg != S_CMP) |=> s_tready)
        else $error("block not ready after final result");

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVE) |-> $past(st.div_last))
        else $error("division left before last step");

endmodule

### hw/rtl/clps_dp.sv
// datapath of the cell list pair search unit: registers, cell memories,
// shared divider and multiplier, output register; depends on clps_pkg

module clps_dp
    import clps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [CUT_BITS-1:0]    cfg_wdata,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast,
    input  clps_cmd_t              cmd,
    output clps_stat_t             st
);

    // configuration
    logic [CUT_BITS-1:0]  cutoff_reg;
    logic [GRID_BITS-1:0] grid_x_reg;
    logic [GRID_BITS-1:0] grid_y_reg;
    logic [GRID_BITS-1:0] grid_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUT_BITS'(4096);
            grid_x_reg <= GRID_BITS'(16);
            grid_y_reg <= GRID_BITS'(16);
            grid_z_reg <= GRID_BITS'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CUTOFF: cutoff_reg <= cfg_wdata;
                REG_GRID_X: grid_x_reg <= cfg_wdata[GRID_BITS-1:0];
                REG_GRID_Y: grid_y_reg <= cfg_wdata[GRID_BITS-1:0];
                REG_GRID_Z: grid_z_reg <= cfg_wdata[GRID_BITS-1:0];
                default:    cutoff_reg <= cutoff_reg;
            endcase
        end
    end

    function automatic logic [GRID_BITS-1:0] eff_grid(input logic [GRID_BITS-1:0] g);
        if (g == '0)
            return GRID_BITS'(1);
        else if (int'(g) > GRID_MAX)
            return GRID_BITS'(GRID_MAX);
        else
            return g;
    endfunction

    logic [CUT_BITS-1:0]  cut;
    logic [GRID_BITS-1:0] gx;
    logic [GRID_BITS-1:0] gy;
    logic [GRID_BITS-1:0] gz;

    assign cut = (cutoff_reg == '0) ? CUT_BITS'(1) : cutoff_reg;
    assign gx  = eff_grid(grid_x_reg);
    assign gy  = eff_grid(grid_y_reg);
    assign gz  = eff_grid(grid_z_reg);

    // latched input item
    logic [ID_BITS-1:0]           pid_reg;
    logic signed [COORD_BITS-1:0] pos_reg [3];
    logic [IN_CW-1:0]             scx_reg;
    logic [IN_CW-1:0]             scy_reg;
    logic [IN_CW-1:0]             scz_reg;
    logic [SL_BITS-1:0]           slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            pid_reg    <= s_tdata[15:0];
            pos_reg[0] <= s_tdata[39:16];
            pos_reg[1] <= s_tdata[63:40];
            pos_reg[2] <= s_tdata[87:64];
            scx_reg    <= s_tdata[92:88];
            scy_reg    <= s_tdata[97:93];
            scz_reg    <= s_tdata[102:98];
            slot_reg   <= s_tdata[104:103];
        end
    end

    // clearing sweep over the fill memory
    logic [CI_BITS-1:0] sweep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else if (cmd.clr_wr)
            sweep_reg <= st.sweep_last ? '0 : sweep_reg + CI_BITS'(1);
    end

    assign st.sweep_last = (sweep_reg == CI_BITS'(NCELLS - 1));

    // restoring divider, one quotient bit per cycle
    logic [COORD_BITS-1:0] dmag_reg;
    logic [COORD_BITS-1:0] dq_reg;
    logic [CUT_BITS-1:0]   drem_reg;
    logic [DCNT_BITS-1:0]  dcnt_reg;
    logic                  dneg_reg;
    logic [CUT_BITS:0]     dtrial;
    logic                  dge;
    logic signed [COORD_BITS-1:0] dpos;

    assign dpos   = pos_reg[cmd.axis];
    assign dtrial = {drem_reg, dmag_reg[COORD_BITS-1]};
    assign dge    = (dtrial >= {1'b0, cut});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            dmag_reg <= dpos[COORD_BITS-1] ? COORD_BITS'(-dpos) : COORD_BITS'(dpos);
            dneg_reg <= dpos[COORD_BITS-1];
            dq_reg   <= '0;
            drem_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dmag_reg <= {dmag_reg[COORD_BITS-2:0], 1'b0};
            dq_reg   <= {dq_reg[COORD_BITS-2:0], dge};
            drem_reg <= dge ? CUT_BITS'(dtrial - {1'b0, cut}) : dtrial[CUT_BITS-1:0];
            dcnt_reg <= dcnt_reg + DCNT_BITS'(1);
        end
    end

    assign st.div_last = (dcnt_reg == DCNT_BITS'(COORD_BITS - 1));

    // load cell coordinates
    logic [CW-1:0]        ldc_reg [3];
    logic                 oob_reg;
    logic [COORD_BITS:0]  dt;
    logic [GRID_BITS-1:0] gsel;

    assign dt   = {1'b0, dq_reg} + {{COORD_BITS{1'b0}}, (drem_reg != '0)};
    assign gsel = (cmd.axis == 2'd0) ? gx : ((cmd.axis == 2'd1) ? gy : gz);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            oob_reg <= 1'b0;
        else if (cmd.div_store)
        begin
            if (dneg_reg)
            begin
                if (dt > (COORD_BITS + 1)'(1))
                    oob_reg <= 1'b1;
                ldc_reg[cmd.axis] <= CW'(1) - dt[CW-1:0];
            end
            else
            begin
                if (dq_reg > COORD_BITS'(gsel))
                    oob_reg <= 1'b1;
                ldc_reg[cmd.axis] <= dq_reg[CW-1:0] + CW'(1);
            end
        end
    end

    // scan cell and loop state
    logic [CI_BITS-1:0]   ld_ci;
    logic [CI_BITS-1:0]   own_ci;
    logic [CI_BITS-1:0]   cur_ci_reg;
    logic [K_BITS-1:0]    k_reg;
    logic [FILL_BITS-1:0] j_reg;
    logic [FILL_BITS-1:0] lim_reg;
    logic [FILL_BITS-1:0] fill_q;
    logic [CI_BITS-1:0]   nbr_ci;

    assign ld_ci  = cell_index(ldc_reg[0], ldc_reg[1], ldc_reg[2]);
    assign own_ci = cell_index(CW'(scx_reg), CW'(scy_reg), CW'(scz_reg));
    assign nbr_ci = own_ci + nbr_off(k_reg + K_BITS'(1));

    assign st.scan_ok = (scx_reg >= IN_CW'(1)) && (scx_reg <= gx) &&
                        (scy_reg >= IN_CW'(1)) && (scy_reg <= gy) &&
                        (scz_reg >= IN_CW'(1)) && (scz_reg <= gz);
    assign st.slot_ok = (FILL_BITS'(slot_reg) < fill_q);
    assign st.more    = (j_reg < lim_reg);
    assign st.nbr_end = (k_reg == K_BITS'(NSHELL));

    always_ff @(posedge clk)
    begin
        if (cmd.me_rd)
        begin
            cur_ci_reg <= own_ci;
            k_reg      <= '0;
            j_reg      <= FILL_BITS'(slot_reg) + FILL_BITS'(1);
            lim_reg    <= fill_q;
        end
        else if (cmd.nbr_next)
        begin
            cur_ci_reg <= nbr_ci;
            k_reg      <= k_reg + K_BITS'(1);
            j_reg      <= '0;
        end
        else if (cmd.lim_latch)
            lim_reg <= fill_q;
        else if (cmd.j_inc)
            j_reg <= j_reg + FILL_BITS'(1);
    end

    // fill count memory
    logic [FILL_BITS-1:0] fill_mem [NCELLS];
    logic                 fill_we;
    logic [CI_BITS-1:0]   fill_wa;
    logic [FILL_BITS-1:0] fill_wd;
    logic [CI_BITS-1:0]   fill_ra;
    logic                 ld_ok;

    assign ld_ok   = !oob_reg && (int'(fill_q) < CELL_CAP);
    assign fill_we = cmd.clr_wr || (cmd.ld_chk && ld_ok);
    assign fill_wa = cmd.clr_wr ? sweep_reg : ld_ci;
    assign fill_wd = cmd.clr_wr ? '0 : fill_q + FILL_BITS'(1);
    assign fill_ra = cmd.ld_rd ? ld_ci : (cmd.sc_rd ? own_ci : nbr_ci);

    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_wa] <= fill_wd;
    end

    always_ff @(posedge clk)
    begin
        fill_q <= fill_mem[fill_ra];
    end

    // particle slot memory
    slot_t              slot_mem [NSLOTS];
    slot_t              slot_q;
    slot_t              slot_wd;
    logic [SA_BITS-1:0] slot_ra;

    assign slot_wd.ident = pid_reg;
    assign slot_wd.px    = pos_reg[0];
    assign slot_wd.py    = pos_reg[1];
    assign slot_wd.pz    = pos_reg[2];
    assign slot_ra = cmd.me_rd ? slot_addr(own_ci, FILL_BITS'(slot_reg))
                               : slot_addr(cur_ci_reg, j_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.ld_chk && ld_ok)
            slot_mem[slot_addr(ld_ci, fill_q)] <= slot_wd;
    end

    always_ff @(posedge clk)
    begin
        slot_q <= slot_mem[slot_ra];
    end

    // distance test
    slot_t                 me_reg;
    logic [DIFF_BITS-1:0]  dabs_reg [3];
    logic                  gt_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [SQ_BITS-1:0]    csq_reg;
    logic signed [DIFF_BITS-1:0] dd [3];
    logic [DIFF_BITS-1:0]  da [3];
    logic [CUT_BITS-1:0]   mop;
    logic [SQ_BITS-1:0]    mprod;

    assign dd[0] = DIFF_BITS'(me_reg.px) - DIFF_BITS'(slot_q.px);
    assign dd[1] = DIFF_BITS'(me_reg.py) - DIFF_BITS'(slot_q.py);
    assign dd[2] = DIFF_BITS'(me_reg.pz) - DIFF_BITS'(slot_q.pz);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            da[i] = dd[i][DIFF_BITS-1] ? DIFF_BITS'(-dd[i]) : DIFF_BITS'(dd[i]);
    end

    assign mop   = (cmd.axis == SQ_CUT) ? cut : dabs_reg[cmd.axis][CUT_BITS-1:0];
    assign mprod = SQ_BITS'(mop) * SQ_BITS'(mop);

    always_ff @(posedge clk)
    begin
        if (cmd.me_latch)
            me_reg <= slot_q;
        if (cmd.diff)
        begin
            for (int i = 0; i < 3; i++)
                dabs_reg[i] <= da[i];
            gt_reg  <= (da[0] > DIFF_BITS'(cut)) || (da[1] > DIFF_BITS'(cut)) ||
                       (da[2] > DIFF_BITS'(cut));
            acc_reg <= '0;
        end
        else if (cmd.sq)
        begin
            if (cmd.axis == SQ_CUT)
                csq_reg <= mprod;
            else
                acc_reg <= acc_reg + ACC_BITS'(mprod);
        end
    end

    assign st.hit = !gt_reg && (acc_reg <= ACC_BITS'(csq_reg));

    // pending pair and result status
    logic               have_pend_reg;
    logic [ID_BITS-1:0] pend_id_reg;
    logic [1:0]         res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            have_pend_reg <= 1'b0;
        else if (cmd.latch || (cmd.emit && !cmd.pend_load))
            have_pend_reg <= 1'b0;
        else if (cmd.pend_load)
            have_pend_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pend_load)
            pend_id_reg <= slot_q.ident;
        if (cmd.latch)
            res_reg <= RES_OK;
        else if (cmd.ld_chk)
            res_reg <= oob_reg ? RES_OOB : (ld_ok ? RES_OK : RES_FULL);
    end

    assign st.have_pend = have_pend_reg;

    // output register
    logic               out_valid_reg;
    logic [ID_BITS-1:0] out_first_reg;
    logic [ID_BITS-1:0] out_second_reg;
    logic               out_pv_reg;
    logic [1:0]         out_st_reg;
    logic               out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_first_reg  <= cmd.emit_pair ? me_reg.ident : '0;
            out_second_reg <= cmd.emit_pair ? pend_id_reg : '0;
            out_pv_reg     <= cmd.emit_pair;
            out_st_reg     <= cmd.emit_pair ? RES_OK : res_reg;
            out_last_reg   <= !cmd.pend_load;
        end
    end

    assign st.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid    = out_valid_reg;
    assign m_tlast     = out_last_reg;
    assign m_tdata     = {5'b0, out_st_reg, out_pv_reg, out_second_reg, out_first_reg};

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> (int'(fill_wd) <= CELL_CAP))
        else $error("fill count above cell capacity");

    a_no_store_oob: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ld_chk && oob_reg) |-> !fill_we)
        else $error("out of grid particle stored");

    a_lim_cap: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.lim_latch) |-> (int'(lim_reg) <= CELL_CAP))
        else $error("neighbour fill above capacity");

endmodule

### hw/rtl/cell_list_pair_search_unit.sv
// Clear sweeps all 5832 cells of the fill memory; load runs three divisions, one per axis;
// scan tests the particle against later slots of its own cell and all slots of the 13
// half-shell neighbour cells, and output stalls hold it; one item in flight at a time, set by the
// shared divider, the single multiplier and the memory read ports.
// Reset: asynchronous, active low; afterwards a pass over all 5832 cells clears the fill
// memory before the first transfer is taken; configuration writes are taken throughout.

module cell_list_pair_search_unit
    import clps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CUT_BITS-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // particle_id, pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, slot
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // first_id, second_id, pair_valid, status
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    clps_cmd_t  cmd;
    clps_stat_t st;

    clps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    clps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
